// ===== hw/rtl/tlvp_pkg.sv =====
package tlvp_pkg;

    // Parse phase of the byte stream.
    typedef enum logic [1:0] {
        PHASE_TYPE   = 2'd0,
        PHASE_LENGTH = 2'd1,
        PHASE_VALUE  = 2'd2,
        PHASE_SKIP   = 2'd3
    } t_phase;

    // Kind of the record being parsed; bit positions of the update mask follow it.
    typedef enum logic [1:0] {
        KIND_ID    = 2'd0,
        KIND_TEMP  = 2'd1,
        KIND_HUMID = 2'd2,
        KIND_OTHER = 2'd3
    } t_kind;

    // Configuration register indexes.
    localparam logic [1:0] CFG_UNIT_ID_CODE     = 2'd0;
    localparam logic [1:0] CFG_TEMPERATURE_CODE = 2'd1;
    localparam logic [1:0] CFG_HUMIDITY_CODE    = 2'd2;

    localparam logic [7:0] RESET_UNIT_ID_CODE     = 8'd1;
    localparam logic [7:0] RESET_TEMPERATURE_CODE = 8'd2;
    localparam logic [7:0] RESET_HUMIDITY_CODE    = 8'd3;

    // Number of value bytes taken for a known record type.
    localparam logic [2:0] VALUE_BYTES = 3'd4;

    typedef struct packed {
        logic [7:0] unit_id;
        logic [7:0] temperature;
        logic [7:0] humidity;
    } t_type_codes;

    typedef struct packed {
        logic        status;
        logic [31:0] unit_id;
        logic [31:0] temperature_bits;
        logic [31:0] humidity_bits;
        logic [2:0]  fields_updated;
    } t_result;

endpackage

// ===== hw/rtl/tlvp_parse_core.sv =====
module tlvp_parse_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    input  tlvp_pkg::t_type_codes i_codes,
    output tlvp_pkg::t_result    o_result
);
    import tlvp_pkg::*;

    t_phase      r_phase, n_phase;
    t_kind       r_kind, n_kind;
    logic [2:0]  r_value_left, n_value_left;
    logic [7:0]  r_decl_left, n_decl_left;
    logic [7:0]  r_skip_left, n_skip_left;
    logic [31:0] r_shift, n_shift;
    logic [31:0] r_id, n_id;
    logic [31:0] r_temp, n_temp;
    logic [31:0] r_humid, n_humid;
    logic [2:0]  r_mask, n_mask;

    t_kind       type_kind;
    logic [7:0]  decl_dec;
    logic [2:0]  value_dec;
    logic [7:0]  skip_dec;

    always_comb begin
        if (i_data_byte == i_codes.unit_id) begin
            type_kind = KIND_ID;
        end else if (i_data_byte == i_codes.temperature) begin
            type_kind = KIND_TEMP;
        end else if (i_data_byte == i_codes.humidity) begin
            type_kind = KIND_HUMID;
        end else begin
            type_kind = KIND_OTHER;
        end
    end

    assign decl_dec  = (r_decl_left != 8'd0) ? r_decl_left - 8'd1 : r_decl_left;
    assign value_dec = (r_value_left != 3'd0) ? r_value_left - 3'd1 : r_value_left;
    assign skip_dec  = (r_skip_left != 8'd0) ? r_skip_left - 8'd1 : r_skip_left;

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PHASE_TYPE: begin
                n_phase = PHASE_LENGTH;
            end
            PHASE_LENGTH: begin
                if (r_kind != KIND_OTHER) begin
                    n_phase = PHASE_VALUE;
                end else if (i_data_byte != 8'd0) begin
                    n_phase = PHASE_SKIP;
                end else begin
                    n_phase = PHASE_TYPE;
                end
            end
            PHASE_VALUE: begin
                if (value_dec == 3'd0) begin
                    n_phase = PHASE_TYPE;
                end
            end
            PHASE_SKIP: begin
                if (skip_dec == 8'd0) begin
                    n_phase = PHASE_TYPE;
                end
            end
            default: n_phase = PHASE_TYPE;
        endcase
    end

    // Counters and value registers.
    always_comb begin
        n_kind       = r_kind;
        n_value_left = r_value_left;
        n_decl_left  = decl_dec;
        n_skip_left  = r_skip_left;
        n_shift      = r_shift;
        n_id         = r_id;
        n_temp       = r_temp;
        n_humid      = r_humid;
        n_mask       = r_mask;
        unique case (r_phase)
            PHASE_TYPE: begin
                n_kind = type_kind;
            end
            PHASE_LENGTH: begin
                if (decl_dec < i_data_byte) begin
                    n_decl_left = i_data_byte;
                end
                if (r_kind != KIND_OTHER) begin
                    n_value_left = VALUE_BYTES;
                    n_shift      = 32'd0;
                end else if (i_data_byte != 8'd0) begin
                    n_skip_left = i_data_byte;
                end
            end
            PHASE_VALUE: begin
                n_shift      = {r_shift[23:0], i_data_byte};
                n_value_left = value_dec;
                if (value_dec == 3'd0) begin
                    case (r_kind)
                        KIND_ID: begin
                            n_id      = n_shift;
                            n_mask[0] = 1'b1;
                        end
                        KIND_TEMP: begin
                            n_temp    = n_shift;
                            n_mask[1] = 1'b1;
                        end
                        default: begin
                            n_humid   = n_shift;
                            n_mask[2] = 1'b1;
                        end
                    endcase
                end
            end
            PHASE_SKIP: begin
                n_skip_left = skip_dec;
            end
            default: ;
        endcase
    end

    // The result reflects this beat's updates; a truncated record or an
    // uncovered declared length fails the buffer.
    always_comb begin
        o_result.status           = (n_phase != PHASE_TYPE) || (n_decl_left != 8'd0);
        o_result.unit_id          = n_id;
        o_result.temperature_bits = n_temp;
        o_result.humidity_bits    = n_humid;
        o_result.fields_updated   = n_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PHASE_TYPE;
            r_kind       <= KIND_ID;
            r_value_left <= 3'd0;
            r_decl_left  <= 8'd0;
            r_skip_left  <= 8'd0;
            r_shift      <= 32'd0;
            r_id         <= 32'd0;
            r_temp       <= 32'd0;
            r_humid      <= 32'd0;
            r_mask       <= 3'd0;
        end else if (i_step) begin
            r_id    <= n_id;
            r_temp  <= n_temp;
            r_humid <= n_humid;
            if (i_last_byte) begin
                // Parse state starts over for the next buffer.
                r_phase      <= PHASE_TYPE;
                r_kind       <= KIND_ID;
                r_value_left <= 3'd0;
                r_decl_left  <= 8'd0;
                r_skip_left  <= 8'd0;
                r_shift      <= 32'd0;
                r_mask       <= 3'd0;
            end else begin
                r_phase      <= n_phase;
                r_kind       <= n_kind;
                r_value_left <= n_value_left;
                r_decl_left  <= n_decl_left;
                r_skip_left  <= n_skip_left;
                r_shift      <= n_shift;
                r_mask       <= n_mask;
            end
        end
    end

endmodule

// ===== hw/rtl/tlv_telemetry_parser.sv =====
// Channel   Direction  Handshake                 Payload
// in        sink       i_in_valid / o_in_stall   i_data_byte, i_last_byte
// out       source     o_out_valid / i_out_stall o_status, o_unit_id,
//                                                o_temperature_bits, o_humidity_bits,
//                                                o_fields_updated
// cfg       sink       i_cfg_we (no wait)        i_cfg_index, i_cfg_wdata
//
// One input beat is taken per cycle unless the input is held. A beat waits in
// the input register until the parse core consumes it, and a final byte's result
// is registered then. The only thing that holds the input is a final byte that finds
// the result register still full and stalled. Reset is synchronous, active low,
// and returns the type codes to 1, 2 and 3 and the value registers to zero.
module tlv_telemetry_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_status,
    output logic [31:0] o_unit_id,
    output logic [31:0] o_temperature_bits,
    output logic [31:0] o_humidity_bits,
    output logic [2:0]  o_fields_updated,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_wdata
);
    import tlvp_pkg::*;

    t_type_codes r_codes;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    logic        r_out_valid;
    t_result     r_out;

    t_result     core_result;
    logic        in_accept;
    logic        step;

    // Configuration writes; an index past the register list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes.unit_id     <= RESET_UNIT_ID_CODE;
            r_codes.temperature <= RESET_TEMPERATURE_CODE;
            r_codes.humidity    <= RESET_HUMIDITY_CODE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_UNIT_ID_CODE:     r_codes.unit_id     <= i_cfg_wdata;
                CFG_TEMPERATURE_CODE: r_codes.temperature <= i_cfg_wdata;
                CFG_HUMIDITY_CODE:    r_codes.humidity    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // The registered beat moves into the parser unless it is a final byte and
    // the result register cannot be freed this cycle.
    assign step       = r_in_valid && (!r_in_last || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !step;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    tlvp_parse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_data_byte (r_in_byte),
        .i_last_byte (r_in_last),
        .i_codes     (r_codes),
        .o_result    (core_result)
    );

    // Result register: loaded on a final byte, held while stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_last) begin
            r_out <= core_result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_out.status;
    assign o_unit_id          = r_out.unit_id;
    assign o_temperature_bits = r_out.temperature_bits;
    assign o_humidity_bits    = r_out.humidity_bits;
    assign o_fields_updated   = r_out.fields_updated;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import tlvp_pkg::*;

    // The run is stopped here if it hangs. This is far above the slowest correct run.
    localparam int unsigned RUN_LIMIT = 200000;
    // Idle cycles allowed after the last report before a code write or the end of the run.
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic [7:0] data;
        logic       is_last;
    } t_beat;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PATTERN,
        STALL_HEAVY
    } t_stall_style;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_status;
    logic [31:0] o_unit_id;
    logic [31:0] o_temperature_bits;
    logic [31:0] o_humidity_bits;
    logic [2:0]  o_fields_updated;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_wdata = '0;

    tlv_telemetry_parser dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_data_byte        (i_data_byte),
        .i_last_byte        (i_last_byte),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_status           (o_status),
        .o_unit_id          (o_unit_id),
        .o_temperature_bits (o_temperature_bits),
        .o_humidity_bits    (o_humidity_bits),
        .o_fields_updated   (o_fields_updated),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shared state between the stimulus thread, the driver and the monitor.
    // ------------------------------------------------------------------

    // Beats waiting to be offered on the input channel.
    t_beat       byte_queue[$];
    // Reports the parser owes us, oldest first.
    t_result     expected_reports[$];

    int          bytes_queued = 0;
    int          bytes_accepted = 0;
    int          frames_sent = 0;
    int          reports_checked = 0;
    int          truncated_reports = 0;
    int          mismatches = 0;

    // Knobs the stimulus thread turns per phase.
    bit           sender_gaps = 1'b1;
    t_stall_style stall_style = STALL_RANDOM;
    bit           holdoff_armed = 1'b0;

    // Type codes as the stimulus thread last wrote them; used to build records.
    t_type_codes  written_codes = '{unit_id: RESET_UNIT_ID_CODE,
                                    temperature: RESET_TEMPERATURE_CODE,
                                    humidity: RESET_HUMIDITY_CODE};

    // ------------------------------------------------------------------
    // Parser model. It tracks the same phase, counters and value registers
    // as the block and produces one report per final byte.
    // ------------------------------------------------------------------
    t_type_codes live_codes;
    t_phase      cur_phase;
    t_kind       cur_kind;
    logic [2:0]  value_left;
    logic [7:0]  owed_bytes;    // bytes still needed to reach the longest declared length
    logic [7:0]  skip_left;
    logic [31:0] shift_acc;
    logic [31:0] id_val;
    logic [31:0] temp_val;
    logic [31:0] humid_val;
    logic [2:0]  upd_mask;

    // Priority order matters when codes collide: unit id first, then
    // temperature, then humidity.
    function automatic t_kind kind_of(input t_type_codes codes, input logic [7:0] t);
        if (t == codes.unit_id) return KIND_ID;
        if (t == codes.temperature) return KIND_TEMP;
        if (t == codes.humidity) return KIND_HUMID;
        return KIND_OTHER;
    endfunction

    task automatic start_buffer();
        cur_phase  = PHASE_TYPE;
        cur_kind   = KIND_ID;
        value_left = '0;
        owed_bytes = '0;
        skip_left  = '0;
        shift_acc  = '0;
        upd_mask   = '0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic is_last);
        t_result rep;
        if (owed_bytes != 0) owed_bytes--;
        case (cur_phase)
            PHASE_TYPE: begin
                cur_kind  = kind_of(live_codes, b);
                cur_phase = PHASE_LENGTH;
            end
            PHASE_LENGTH: begin
                if (owed_bytes < b) owed_bytes = b;
                // A known type always takes exactly four value bytes, whatever its length says.
                if (cur_kind != KIND_OTHER) begin
                    cur_phase  = PHASE_VALUE;
                    value_left = VALUE_BYTES;
                    shift_acc  = '0;
                end else if (b != 0) begin
                    cur_phase = PHASE_SKIP;
                    skip_left = b;
                end else begin
                    cur_phase = PHASE_TYPE;
                end
            end
            PHASE_VALUE: begin
                shift_acc = {shift_acc[23:0], b};
                if (value_left != 0) value_left--;
                if (value_left == 0) begin
                    case (cur_kind)
                        KIND_ID:   id_val = shift_acc;
                        KIND_TEMP: temp_val = shift_acc;
                        default:   humid_val = shift_acc;
                    endcase
                    upd_mask  = upd_mask | (3'b001 << cur_kind);
                    cur_phase = PHASE_TYPE;
                end
            end
            default: begin
                if (skip_left != 0) skip_left--;
                if (skip_left == 0) cur_phase = PHASE_TYPE;
            end
        endcase
        if (is_last) begin
            // The buffer fails if it stops mid-record or short of a declared length.
            rep.status           = (cur_phase != PHASE_TYPE) || (owed_bytes != 0);
            rep.unit_id          = id_val;
            rep.temperature_bits = temp_val;
            rep.humidity_bits    = humid_val;
            rep.fields_updated   = upd_mask;
            if (rep.status) truncated_reports++;
            expected_reports.push_back(rep);
            start_buffer();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offers beats from the queue in bursts of random length with
    // random gaps between them. A stalled beat is held unchanged.
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin : drive_bytes
        t_beat beat;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (gap_left > 0) begin
                gap_left   <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (byte_queue.size() > 0) begin
                beat = byte_queue.pop_front();
                i_data_byte <= beat.data;
                i_last_byte <= beat.is_last;
                i_in_valid  <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= sender_gaps ? $urandom_range(0, 6) : 0;
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stalls the result channel according to the current style.
    // Once armed, it holds off for a long stretch so the result register
    // stays full and the next final byte backs up the input.
    // ------------------------------------------------------------------
    int hold_cycles = 0;
    int pattern_pos = 0;
    bit holdoff_taken = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            pattern_pos <= pattern_pos + 1;
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                i_out_stall <= 1'b1;
            end else if (holdoff_armed && !holdoff_taken) begin
                holdoff_taken <= 1'b1;
                hold_cycles   <= 400;
                i_out_stall   <= 1'b1;
            end else begin
                case (stall_style)
                    STALL_NONE: i_out_stall <= 1'b0;
                    STALL_RANDOM: begin
                        if ($urandom_range(0, 299) == 0) hold_cycles <= $urandom_range(20, 80);
                        i_out_stall <= ($urandom_range(0, 2) == 0);
                    end
                    STALL_PATTERN: i_out_stall <= (pattern_pos % 7) < 3;
                    default: i_out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: follows code writes and accepted input beats with the model,
    // then checks each accepted report against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_ports
        t_result want;
        if (!i_rst_n) begin
            live_codes = '{unit_id: RESET_UNIT_ID_CODE,
                           temperature: RESET_TEMPERATURE_CODE,
                           humidity: RESET_HUMIDITY_CODE};
            id_val    = '0;
            temp_val  = '0;
            humid_val = '0;
            start_buffer();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_UNIT_ID_CODE:     live_codes.unit_id = i_cfg_wdata;
                    CFG_TEMPERATURE_CODE: live_codes.temperature = i_cfg_wdata;
                    CFG_HUMIDITY_CODE:    live_codes.humidity = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                parse_byte(i_data_byte, i_last_byte);
                bytes_accepted <= bytes_accepted + 1;
            end
            if (o_out_valid && !i_out_stall) begin
                reports_checked++;
                if (expected_reports.size() == 0) begin
                    $error("report with no buffer pending: status %0d mask %0d",
                           o_status, o_fields_updated);
                    mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("status", 32'(want.status), 32'(o_status));
                    check_field("unit_id", want.unit_id, o_unit_id);
                    check_field("temperature_bits", want.temperature_bits, o_temperature_bits);
                    check_field("humidity_bits", want.humidity_bits, o_humidity_bits);
                    check_field("fields_updated", 32'(want.fields_updated),
                                32'(o_fields_updated));
                end
            end
        end
    end

    // Watchdog.
    int unsigned cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("tlv_telemetry_parser test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. A buffer is assembled in frame_bytes, then shipped
    // whole or cut short.
    // ------------------------------------------------------------------
    logic [7:0] frame_bytes[$];
    int         frame_owed;

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        t_beat beat;
        beat.data    = b;
        beat.is_last = is_last;
        byte_queue.push_back(beat);
        bytes_queued++;
    endtask

    task automatic ship_frame(input int keep);
        for (int k = 0; k < keep; k++) send_byte(frame_bytes[k], k == keep - 1);
        frame_bytes.delete();
        frames_sent++;
    endtask

    // Appends a byte and keeps count of how far the declared lengths still reach.
    task automatic put(input logic [7:0] b);
        if (frame_owed != 0) frame_owed--;
        frame_bytes.push_back(b);
    endtask

    task automatic put_length(input logic [7:0] len);
        put(len);
        if (frame_owed < len) frame_owed = len;
    endtask

    function automatic logic [7:0] other_code();
        logic [7:0] c;
        do c = 8'($urandom); while (kind_of(written_codes, c) != KIND_OTHER);
        return c;
    endfunction

    // Well-formed buffer of n records with random content. Known types mostly
    // declare four bytes, sometimes fewer or more; a short tail of empty
    // unknown records then covers any length declared past the end.
    task automatic build_frame(input int n_records);
        int pick;
        int len;
        for (int r = 0; r < n_records; r++) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                case (pick / 2)
                    0:       put(written_codes.unit_id);
                    1:       put(written_codes.temperature);
                    default: put(written_codes.humidity);
                endcase
                len = $urandom_range(0, 9);
                if (len < 6) put_length(8'd4);
                else if (len < 8) put_length(8'($urandom_range(0, 3)));
                else put_length(8'($urandom_range(5, 10)));
                repeat (4) put(8'($urandom));
            end else begin
                put(other_code());
                len = ($urandom_range(0, 24) == 0) ? $urandom_range(20, 255)
                                                   : $urandom_range(0, 6);
                put_length(8'(len));
                repeat (len) put(8'($urandom));
            end
        end
        while (frame_owed != 0) begin
            put(other_code());
            put_length(8'd0);
        end
    endtask

    task automatic random_frame();
        int pick;
        frame_owed = 0;
        pick = $urandom_range(0, 19);
        if (pick < 15) begin
            build_frame($urandom_range(1, 4));
            ship_frame(frame_bytes.size());
        end else if (pick < 18) begin
            // Cut short anywhere: after a type byte, inside a value or a skip,
            // or before a declared length is covered.
            build_frame($urandom_range(1, 3));
            ship_frame(frame_bytes.size() > 1 ? $urandom_range(1, frame_bytes.size() - 1) : 1);
        end else begin
            repeat ($urandom_range(1, 10)) frame_bytes.push_back(8'($urandom));
            ship_frame(frame_bytes.size());
        end
    endtask

    // Waits until every beat is taken and every report has come back.
    task automatic wait_drained();
        while (bytes_accepted != bytes_queued || expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_codes(input logic [7:0] id_code, input logic [7:0] temp_code,
                               input logic [7:0] humid_code);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_UNIT_ID_CODE;
        i_cfg_wdata <= id_code;
        @(posedge i_clk);
        i_cfg_index <= CFG_TEMPERATURE_CODE;
        i_cfg_wdata <= temp_code;
        @(posedge i_clk);
        i_cfg_index <= CFG_HUMIDITY_CODE;
        i_cfg_wdata <= humid_code;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        written_codes = '{unit_id: id_code, temperature: temp_code, humidity: humid_code};
    endtask

    task automatic run_phase(input int n_bytes, input bit gaps, input t_stall_style style);
        int stop_at;
        stop_at     = bytes_queued + n_bytes;
        sender_gaps = gaps;
        stall_style = style;
        while (bytes_queued < stop_at) random_frame();
        wait_drained();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed buffers with the reset codes.
        // Id and temperature records complete, the temperature one declares
        // nine bytes, and an unknown record skips one byte; the buffer ends
        // two bytes short, so it fails yet still reports both new values.
        frame_bytes = {8'h01, 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                       8'h02, 8'h09, 8'h80, 8'h00, 8'h00, 8'h01,
                       8'hFF, 8'h01, 8'hAA};
        ship_frame(frame_bytes.size());
        // Humidity declares zero bytes but still takes four, then an unknown
        // record of length zero closes the buffer cleanly.
        frame_bytes = {8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        ship_frame(frame_bytes.size());
        // A buffer that stops right after its type byte.
        frame_bytes = {8'h01};
        ship_frame(frame_bytes.size());

        run_phase(120, 1'b1, STALL_RANDOM);

        // Code extremes, full rate on both sides.
        write_codes(8'h00, 8'hFF, 8'h80);
        run_phase(140, 1'b0, STALL_NONE);

        // Long receiver hold-off while the sender keeps offering beats.
        write_codes(8'hFF, 8'hFE, 8'h00);
        holdoff_armed = 1'b1;
        run_phase(140, 1'b0, STALL_NONE);

        // All three codes equal: every known record is a unit id.
        write_codes(8'h5A, 8'h5A, 8'h5A);
        run_phase(140, 1'b1, STALL_PATTERN);

        // Temperature and humidity share a code; temperature wins.
        write_codes(8'h10, 8'h20, 8'h20);
        run_phase(140, 1'b1, STALL_HEAVY);

        write_codes(8'($urandom), 8'($urandom), 8'($urandom));
        run_phase(140, 1'b1, STALL_RANDOM);

        write_codes(RESET_UNIT_ID_CODE, RESET_TEMPERATURE_CODE, RESET_HUMIDITY_CODE);
        run_phase(140, 1'b0, STALL_RANDOM);

        $display("Sent %0d bytes in %0d buffers under seven type-code settings.",
                 bytes_queued, frames_sent);
        $display("Checked %0d reports, %0d of them for failed buffers.",
                 reports_checked, truncated_reports);
        if (mismatches == 0) begin
            $display("tlv_telemetry_parser test passed");
        end else begin
            $display("tlv_telemetry_parser test failed");
        end
        $finish;
    end

endmodule
